// ===== src/gcid_pkg.sv =====
package gcid_pkg;

    localparam int COORD_BITS   = 10;
    localparam int MORTON_W     = 3 * COORD_BITS;
    localparam int COUNT_W      = 11;
    localparam int ID_W         = 30;
    localparam int CYZ_W        = 2 * COUNT_W;
    localparam int TOTAL_W      = 33;
    localparam int LIN_W        = 32;
    localparam int LIN_B_W      = CYZ_W;
    localparam int MULT_W       = 10;
    localparam int PROD_W       = LIN_W + MULT_W;
    localparam int DIV_STEPS    = PROD_W;
    localparam int S_TDATA_W    = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((ID_W + 7) / 8) * 8;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = COUNT_W;

    localparam logic [MULT_W-1:0] SHUFFLE_MULT = MULT_W'(833);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_X   = 3'd0,
        CFG_COUNT_Y   = 3'd1,
        CFG_COUNT_Z   = 3'd2,
        CFG_MORTON    = 3'd3,
        CFG_SHUFFLE   = 3'd4
    } cfg_index_t;

    // one word in the remainder pipeline
    typedef struct packed {
        logic              valid;
        logic              shuf;
        logic [PROD_W-1:0] rem;
    } rem_stage_t;

    // bit b of each coordinate lands at bit 3b (i), 3b+1 (j), 3b+2 (k)
    function automatic logic [MORTON_W-1:0] morton3(
        input logic [COORD_BITS-1:0] ci,
        input logic [COORD_BITS-1:0] cj,
        input logic [COORD_BITS-1:0] ck
    );
        logic [MORTON_W-1:0] r;
        r = '0;
        for (int b = 0; b < COORD_BITS; b++) begin
            r[3*b]     = ci[b];
            r[3*b + 1] = cj[b];
            r[3*b + 2] = ck[b];
        end
        return r;
    endfunction

endpackage

// ===== src/grid_cell_id_generator_top.sv =====
// Grid cell id generator. Each word on the s_ side carries one grid coordinate
// (i, j, k) and yields exactly one word on the m_ side carrying a 30-bit cell id:
// either the Z-order code of the low 10 bits of each coordinate (i in bit 0,
// j in bit 1, k in bit 2) or the row-major index i*ny*nz + j*nz + k, optionally
// scrambled to (id*833) mod (nx*ny*nz) (skipped when that count is zero).
// Throughput is one word per cycle while the pipe advances. A word passes the
// front stages (input register, operand products, index sum, x833 product),
// 42 restoring remainder stages (one quotient bit each of the 42-bit product)
// and the output register on its way to m_tvalid. The whole pipe advances together whenever
// the output register is empty or being taken, so s_tready follows m_tready.
// Configuration writes are always accepted (cfg_ready tied high) and must only
// be made while no word is in flight; an out-of-range index is ignored.
module grid_cell_id_generator_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gcid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gcid_pkg::CFG_DATA_W-1:0]   cfg_data,
    // coordinate input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gcid_pkg::S_TDATA_W-1:0]    s_tdata,  // [9:0] coord_i, [19:10] coord_j,
                                                        // [29:20] coord_k, rest zero
    // cell id output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gcid_pkg::M_TDATA_W-1:0]    m_tdata   // [29:0] cell_id, rest zero
);
    import gcid_pkg::*;

    // configuration registers
    logic [COUNT_W-1:0] count_x_reg, count_y_reg, count_z_reg;
    logic               morton_reg, shuffle_reg;

    // values derived from configuration; after a write they settle in turn in
    // cyz_reg, total_reg and shuf_on_reg, before any word reaches the stage that needs them
    logic [CYZ_W-1:0]   cyz_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               shuf_on_reg;

    // stage 0: input register
    logic                  v0_reg;
    logic [COORD_BITS-1:0] ci_reg, cj_reg, ck_reg;
    // stage 1: operand products and Morton code
    logic                  v1_reg;
    logic [LIN_W-1:0]      lin_a_reg;
    logic [LIN_B_W-1:0]    lin_b_reg;
    logic [MORTON_W-1:0]   morton_code_reg;
    // stage 2: unshuffled id
    logic                  v2_reg;
    logic [LIN_W-1:0]      id_reg;
    // stage 3: x833 product (or id passed through)
    rem_stage_t            prod_reg;
    rem_stage_t            rem_out;
    // output register
    logic                  out_valid_reg;
    logic [ID_W-1:0]       cell_id_reg;

    logic en;
    cfg_index_t cfg_sel;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;
    assign cfg_sel   = cfg_index_t'(cfg_index);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_x_reg <= COUNT_W'(1);
            count_y_reg <= COUNT_W'(1);
            count_z_reg <= COUNT_W'(1);
            morton_reg  <= 1'b0;
            shuffle_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_sel)
                CFG_COUNT_X: count_x_reg <= cfg_data;
                CFG_COUNT_Y: count_y_reg <= cfg_data;
                CFG_COUNT_Z: count_z_reg <= cfg_data;
                CFG_MORTON:  morton_reg  <= cfg_data[0];
                CFG_SHUFFLE: shuffle_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cyz_reg     <= CYZ_W'(1);
            total_reg   <= TOTAL_W'(1);
            shuf_on_reg <= 1'b0;
        end else begin
            cyz_reg     <= CYZ_W'(count_y_reg) * CYZ_W'(count_z_reg);
            total_reg   <= TOTAL_W'(count_x_reg * cyz_reg);
            shuf_on_reg <= shuffle_reg && (total_reg != '0);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg         <= s_tvalid;
            v1_reg         <= v0_reg;
            v2_reg         <= v1_reg;
            out_valid_reg  <= rem_out.valid;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            ci_reg <= s_tdata[COORD_BITS-1:0];
            cj_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            ck_reg <= s_tdata[3*COORD_BITS-1:2*COORD_BITS];

            lin_a_reg       <= LIN_W'(ci_reg * cyz_reg);
            lin_b_reg       <= LIN_B_W'(cj_reg * count_z_reg) + LIN_B_W'(ck_reg);
            morton_code_reg <= morton3(ci_reg, cj_reg, ck_reg);

            id_reg <= morton_reg ? LIN_W'(morton_code_reg)
                                 : lin_a_reg + LIN_W'(lin_b_reg);

            cell_id_reg <= rem_out.rem[ID_W-1:0];
        end
    end

    // x833 product word, valid bit kept with it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_reg.valid <= 1'b0;
        end else if (en) begin
            prod_reg.valid <= v2_reg;
            prod_reg.shuf  <= shuf_on_reg;
            prod_reg.rem   <= shuf_on_reg ? PROD_W'(id_reg * SHUFFLE_MULT)
                                          : PROD_W'(id_reg);
        end
    end

    // remainder by the total cell count (words with shuf clear pass unchanged)
    gcid_rem_pipe u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .total     (total_reg),
        .in_stage  (prod_reg),
        .out_stage (rem_out)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'(cell_id_reg);

endmodule

// ===== src/gcid_rem_pipe.sv =====
module gcid_rem_pipe (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [gcid_pkg::TOTAL_W-1:0] total,
    input  gcid_pkg::rem_stage_t in_stage,
    output gcid_pkg::rem_stage_t out_stage
);
    import gcid_pkg::*;

    // restoring remainder, one quotient bit per stage, MSB first
    rem_stage_t stage_reg [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        localparam int SHIFT = PROD_W - 1 - g;
        rem_stage_t cur;
        rem_stage_t nxt;
        logic [PROD_W-1:0] hi;
        logic              take;

        if (g == 0) begin : g_first
            assign cur = in_stage;
        end else begin : g_rest
            assign cur = stage_reg[g-1];
        end

        always_comb begin
            hi       = cur.rem >> SHIFT;
            take     = cur.shuf && (hi >= PROD_W'(total));
            nxt      = cur;
            if (take) begin
                nxt.rem = cur.rem - (PROD_W'(total) << SHIFT);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stage_reg[g].valid <= 1'b0;
            end else if (en) begin
                stage_reg[g] <= nxt;
            end
        end
    end

    assign out_stage = stage_reg[DIV_STEPS-1];

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcid_pkg::*;

    // acceptance to m_tvalid through the block's pipe
    localparam int PIPE_LATENCY = 46;
    // chance in a hundred that either side idles in a cycle
    localparam int IDLE_PCT = 32;
    // first register index that the block does not decode
    localparam int CFG_FIRST_UNUSED = int'(CFG_SHUFFLE) + 1;
    localparam int MAX_REPORTS = 10;

    // one coordinate word; the last field lands in the lowest bits
    typedef struct packed {
        logic [COORD_BITS-1:0] k;
        logic [COORD_BITS-1:0] j;
        logic [COORD_BITS-1:0] i;
    } coord_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;     // [9:0] coord_i, [19:10] coord_j, [29:20] coord_k
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;     // [29:0] cell_id

    // our copy of the register file, updated on each accepted write
    logic [COUNT_W-1:0]    grid_nx;
    logic [COUNT_W-1:0]    grid_ny;
    logic [COUNT_W-1:0]    grid_nz;
    logic                  use_morton;
    logic                  use_scramble;

    // cell ids still owed by the block, oldest first
    logic [ID_W-1:0]       pending_ids[$];
    int                    mismatch_count;

    // both sides stop idling while this is set
    logic                  steady;
    // receiver hold-off, counted down by the receiver process
    int                    hold_left;

    grid_cell_id_generator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Expected id for one coordinate under the current register copy.
    // Everything is held at 64 bits and only the final id is cut to 30 bits.
    function automatic logic [ID_W-1:0] predict_cell_id(input coord_t c);
        logic [63:0] id;
        logic [63:0] cells;
        id = '0;
        if (use_morton) begin
            // bit b of i, j, k goes to 3b, 3b+1, 3b+2
            for (int b = 0; b < COORD_BITS; b++) begin
                id[3*b]     = c.i[b];
                id[3*b + 1] = c.j[b];
                id[3*b + 2] = c.k[b];
            end
        end else begin
            id = 64'(c.i) * 64'(grid_ny) * 64'(grid_nz) + 64'(c.j) * 64'(grid_nz) + 64'(c.k);
        end
        cells = 64'(grid_nx) * 64'(grid_ny) * 64'(grid_nz);
        // a zero cell count skips the scramble altogether
        if (use_scramble && cells != 0)
            id = (id * 64'(SHUFFLE_MULT)) % cells;
        return id[ID_W-1:0];
    endfunction

    // Counts: the extremes, zero, powers of two, and values past 1024.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 13))
            0: return COUNT_W'(1);
            1: return COUNT_W'(1024);
            2: return COUNT_W'(2047);
            3: return COUNT_W'(0);
            4: return COUNT_W'(1 << $urandom_range(0, 10));
            5: return COUNT_W'($urandom_range(1025, 2047));
            default: return COUNT_W'($urandom_range(1, 1024));
        endcase
    endfunction

    // Mostly a cell inside the grid, sometimes any 10-bit value.
    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COUNT_W-1:0] n);
        int lim;
        lim = (n > 1024) ? 1024 : int'(n);
        if (lim == 0 || $urandom_range(0, 99) < 30)
            return COORD_BITS'($urandom);
        return COORD_BITS'($urandom_range(0, lim - 1));
    endfunction

    // Offer one coordinate word, with random gaps in front of it, and log the
    // id it must produce once the handshake completes.
    task automatic send_coord(input logic [COORD_BITS-1:0] ci, cj, ck);
        coord_t c;
        c.i = ci;
        c.j = cj;
        c.k = ck;
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(c);
        do @(posedge aclk); while (!s_tready);
        pending_ids.insert(pending_ids.size(), predict_cell_id(c));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_COUNT_X: grid_nx = val;
            CFG_COUNT_Y: grid_ny = val;
            CFG_COUNT_Z: grid_nz = val;
            CFG_MORTON:  use_morton = val[0];
            CFG_SHUFFLE: use_scramble = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every owed id, then let the pipe run dry.
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_ids.size() != 0)
            @(negedge aclk);
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
    endtask

    // Whole register set, written only once the block is empty. Mode bits go
    // out with junk in the unused upper data bits.
    task automatic set_grid(input logic [COUNT_W-1:0] nx, ny, nz,
                            input logic morton, scramble);
        settle();
        write_reg(CFG_COUNT_X, nx);
        write_reg(CFG_COUNT_Y, ny);
        write_reg(CFG_COUNT_Z, nz);
        write_reg(CFG_MORTON, {(CFG_DATA_W-1)'($urandom), morton});
        write_reg(CFG_SHUFFLE, {(CFG_DATA_W-1)'($urandom), scramble});
    endtask

    // Registers straight out of reset: counts of one, row-major, no scramble,
    // so the id is just i + j + k.
    task automatic test_reset_state();
        send_coord('0, '0, '0);
        send_coord('1, '1, '1);
        send_coord(10'h155, 10'h2aa, 10'h155);
    endtask

    // Z-order interleave, each axis on its own and all bits at once.
    task automatic test_morton_interleave();
        set_grid(COUNT_W'(8), COUNT_W'(8), COUNT_W'(8), 1'b1, 1'b0);
        send_coord('0, '0, '0);
        send_coord('1, '1, '1);
        send_coord('1, '0, '0);
        send_coord('0, '1, '0);
        send_coord('0, '0, '1);
        send_coord(10'h2aa, 10'h155, 10'h3c3);
    endtask

    // Row-major index on a small box, including a coordinate off the grid.
    task automatic test_linear_index();
        set_grid(COUNT_W'(4), COUNT_W'(5), COUNT_W'(6), 1'b0, 1'b0);
        send_coord('0, '0, '0);
        send_coord(10'd3, 10'd4, 10'd5);
        send_coord(10'd1, 10'd2, 10'd3);
        send_coord('1, '1, '1);
    endtask

    // x833 mod cell count, on a row-major index and on a Morton code in a
    // grid that is not a power-of-two cube (where the map folds ids together).
    task automatic test_scramble();
        set_grid(COUNT_W'(4), COUNT_W'(5), COUNT_W'(6), 1'b0, 1'b1);
        send_coord(10'd3, 10'd4, 10'd5);
        send_coord(10'd2, 10'd1, 10'd0);
        set_grid(COUNT_W'(3), COUNT_W'(3), COUNT_W'(3), 1'b1, 1'b1);
        send_coord(10'd2, 10'd2, 10'd2);
        send_coord('1, '1, '1);
    endtask

    // A count of zero means a cell count of zero: scramble is bypassed.
    task automatic test_zero_count();
        set_grid(COUNT_W'(7), COUNT_W'(9), COUNT_W'(0), 1'b0, 1'b1);
        send_coord(10'd5, 10'd6, 10'd7);
        send_coord('1, '1, '1);
        settle();
        write_reg(CFG_MORTON, CFG_DATA_W'(1));
        send_coord('1, 10'h0f0, 10'h00f);
    endtask

    // Counts beyond 1024 taken as written; the row-major id wraps past 30 bits.
    task automatic test_wide_counts();
        set_grid('1, '1, '1, 1'b0, 1'b0);
        send_coord('1, '1, '1);
        send_coord(10'd512, '0, '1);
        settle();
        write_reg(CFG_SHUFFLE, CFG_DATA_W'(1));
        send_coord('1, '1, '1);
    endtask

    // Writes to undecoded indices must leave every register alone.
    task automatic test_unused_index();
        set_grid(COUNT_W'(11), COUNT_W'(13), COUNT_W'(17), 1'b0, 1'b1);
        for (int n = CFG_FIRST_UNUSED; n < 2**CFG_IDX_W; n++)
            write_reg(CFG_IDX_W'(n), '1);
        send_coord(10'd10, 10'd12, 10'd16);
    endtask

    // Random register sets, each followed by a batch of random coordinates.
    // The first batch sits on the 1024-cube, one batch runs with no idling.
    task automatic test_random_grids();
        logic [COUNT_W-1:0] nx, ny, nz;
        for (int phase = 0; phase < 8; phase++) begin
            if (phase == 0) begin
                nx = COUNT_W'(1024);
                ny = COUNT_W'(1024);
                nz = COUNT_W'(1024);
            end else begin
                nx = pick_count();
                ny = pick_count();
                nz = pick_count();
            end
            set_grid(nx, ny, nz, 1'($urandom), 1'($urandom));
            steady = (phase == 3);
            repeat (150)
                send_coord(pick_coord(nx), pick_coord(ny), pick_coord(nz));
            steady = 1'b0;
        end
    endtask

    // Receiver goes quiet for a long while; the sender keeps offering words
    // until the pipe is full and s_tready drops.
    task automatic test_backpressure();
        logic [COUNT_W-1:0] nx, ny, nz;
        nx = pick_count();
        ny = pick_count();
        nz = pick_count();
        set_grid(nx, ny, nz, 1'($urandom), 1'b1);
        hold_left = 300;
        repeat (120)
            send_coord(pick_coord(nx), pick_coord(ny), pick_coord(nz));
    endtask

    // Receiver: random idling, a hold-off when asked for, one assignment a cycle.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Each id taken is matched against the oldest one owed.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ids.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: unexpected word, m_tdata=%h", $realtime, m_tdata);
                mismatch_count++;
            end else if (m_tdata !== M_TDATA_W'(pending_ids[0])) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("%0t: cell_id expected %h, got %h", $realtime,
                             M_TDATA_W'(pending_ids[0]), m_tdata);
                mismatch_count++;
                void'(pending_ids.pop_front());
            end else begin
                void'(pending_ids.pop_front());
            end
        end
    end

    // Run limit; a correct run needs a small fraction of this.
    initial begin
        #200_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        steady         = 1'b0;
        hold_left      = 0;
        mismatch_count = 0;
        grid_nx        = COUNT_W'(1);
        grid_ny        = COUNT_W'(1);
        grid_nz        = COUNT_W'(1);
        use_morton     = 1'b0;
        use_scramble   = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_morton_interleave();
        test_linear_index();
        test_scramble();
        test_zero_count();
        test_wide_counts();
        test_unused_index();
        test_random_grids();
        test_backpressure();

        // every id in, then the pipe left to run dry for strays
        settle();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
